// ===== design/rmq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types and constants for the rotation matrix to quaternion block.
// ----------------------------------------------------------------------------
package rmq_pkg;

    localparam int FRAC_BITS_DEF = 14;
    localparam int DATA_W        = 16;   // matrix entries and signed parts
    localparam int OUT_W         = 15;   // unsigned scalar part
    localparam int DIFF_W        = DATA_W + 1;

    localparam logic [OUT_W-1:0] MAG_MAX = {OUT_W{1'b1}};

    typedef struct packed {
        logic signed [DATA_W-1:0] m00;
        logic signed [DATA_W-1:0] m01;
        logic signed [DATA_W-1:0] m02;
        logic signed [DATA_W-1:0] m10;
        logic signed [DATA_W-1:0] m11;
        logic signed [DATA_W-1:0] m12;
        logic signed [DATA_W-1:0] m20;
        logic signed [DATA_W-1:0] m21;
        logic signed [DATA_W-1:0] m22;
    } mat_t;

    typedef struct packed {
        logic        [OUT_W-1:0]  qw;
        logic signed [DATA_W-1:0] qx;
        logic signed [DATA_W-1:0] qy;
        logic signed [DATA_W-1:0] qz;
    } quat_t;

    // sign flags of the three vector parts
    typedef struct packed {
        logic x;
        logic y;
        logic z;
    } sign_t;

endpackage

// ===== design/rmq_sqrt_pipe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_sqrt_pipe
// Pipelined integer square root, one root bit resolved per register stage.
// ----------------------------------------------------------------------------
module rmq_sqrt_pipe #(
    parameter int ROOT_W = 16
) (
    input  logic                  clk,
    input  logic [ROOT_W-1:0]     en,     // load enable, one per stage
    input  logic [2*ROOT_W-1:0]   rad,
    output logic [ROOT_W-1:0]     root
);

    localparam int RAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 1;
    localparam int ACC_W = REM_W + 2;

    logic [RAD_W-1:0]  rad_reg  [ROOT_W];
    logic [RAD_W-1:0]  rad_next [ROOT_W];
    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [REM_W-1:0]  rem_next [ROOT_W];
    logic [ROOT_W-1:0] root_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_next [ROOT_W];

    for (genvar j = 0; j < ROOT_W; j++)
    begin : g_stage
        logic [RAD_W-1:0]  rad_in;
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [ACC_W-1:0]  acc;
        logic [ACC_W-1:0]  trial;
        logic              ge;

        if (j == 0)
        begin : g_first
            assign rad_in  = rad;
            assign rem_in  = '0;
            assign root_in = '0;
        end
        else
        begin : g_rest
            assign rad_in  = rad_reg[j-1];
            assign rem_in  = rem_reg[j-1];
            assign root_in = root_reg[j-1];
        end

        // bring down the next two radicand bits, try 4*root + 1
        assign acc   = {rem_in, rad_in[RAD_W-1 -: 2]};
        assign trial = {1'b0, root_in, 2'b01};
        assign ge    = (acc >= trial);

        assign rem_next[j]  = ge ? REM_W'(acc - trial) : REM_W'(acc);
        assign root_next[j] = {root_in[ROOT_W-2:0], ge};
        assign rad_next[j]  = rad_in << 2;

        always_ff @(posedge clk)
        begin
            if (en[j])
            begin
                rad_reg[j]  <= rad_next[j];
                rem_reg[j]  <= rem_next[j];
                root_reg[j] <= root_next[j];
            end
        end
    end

    assign root = root_reg[ROOT_W-1];

endmodule

// ===== design/rotation_matrix_to_quaternion.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Converts a Q1.14 rotation matrix to a quaternion (w, x, y, z), with the
// magnitudes from four pipelined square roots and the signs of x, y, z taken
// from the off-diagonal differences.
// ----------------------------------------------------------------------------
//  channel | dir | handshake               | payload
//  --------+-----+-------------------------+----------------------
//  mat     | in  | mat_valid / mat_ready   | mat  (nine entries)
//  quat    | out | quat_valid / quat_ready | quat (qw qx qy qz)
//
//  One item per cycle sustained while quat_ready stays high. One stage forms
//  the diagonal sums, one stage per root bit in the square roots, one output
//  register.
//  Reset clears only the stage valid bits.
//  A stall fills bubbles first; each stage holds while it is full and the
//  one after it is full and blocked.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           mat_valid,
    output logic           mat_ready,
    input  rmq_pkg::mat_t  mat,
    output logic           quat_valid,
    input  logic           quat_ready,
    output rmq_pkg::quat_t quat
);

    import rmq_pkg::*;

    localparam int SUM_W   = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
    localparam int RAD_RAW = SUM_W - 1 + FRAC_BITS;
    localparam int ROOT_W  = (RAD_RAW + 1) / 2;
    localparam int RAD_W   = 2 * ROOT_W;
    localparam int MAG_W   = ROOT_W - 1;
    localparam int EXT_W   = (MAG_W > OUT_W) ? MAG_W : OUT_W;
    localparam int STAGES  = ROOT_W + 2;

    localparam logic signed [SUM_W-1:0] ONE = SUM_W'(64'sd1 <<< FRAC_BITS);

    // ---------------- pipeline control ----------------
    logic [STAGES:0]   en;
    logic [STAGES-1:0] v_reg;
    logic [STAGES-1:0] v_next;

    assign en[STAGES] = quat_ready;
    for (genvar k = 0; k < STAGES; k++)
    begin : g_ctrl
        assign en[k] = !v_reg[k] || en[k+1];
    end

    assign v_next = (en[STAGES-1:0] & {v_reg[STAGES-2:0], mat_valid})
                  | (~en[STAGES-1:0] & v_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign mat_ready  = en[0];
    assign quat_valid = v_reg[STAGES-1];

    // ---------------- stage 0: diagonal sums and signs ----------------
    logic signed [SUM_W-1:0]  e00, e11, e22;
    logic signed [SUM_W-1:0]  sw, sx, sy, sz;
    logic signed [DIFF_W-1:0] dx, dy, dz;
    logic [RAD_W-1:0]         rad_w_next, rad_x_next, rad_y_next, rad_z_next;
    logic [RAD_W-1:0]         rad_w_reg, rad_x_reg, rad_y_reg, rad_z_reg;
    sign_t                    sgn_next;
    sign_t                    sgn_reg [ROOT_W+1];

    assign e00 = SUM_W'(mat.m00);
    assign e11 = SUM_W'(mat.m11);
    assign e22 = SUM_W'(mat.m22);

    assign sw = ONE + e00 + e11 + e22;
    assign sx = ONE + e00 - e11 - e22;
    assign sy = ONE - e00 + e11 - e22;
    assign sz = ONE - e00 - e11 + e22;

    // radicand is S << FRAC_BITS, negative or zero sums give zero
    assign rad_w_next = (!sw[SUM_W-1] && (sw != '0))
                      ? RAD_W'({sw[SUM_W-2:0], {FRAC_BITS{1'b0}}}) : '0;
    assign rad_x_next = (!sx[SUM_W-1] && (sx != '0))
                      ? RAD_W'({sx[SUM_W-2:0], {FRAC_BITS{1'b0}}}) : '0;
    assign rad_y_next = (!sy[SUM_W-1] && (sy != '0))
                      ? RAD_W'({sy[SUM_W-2:0], {FRAC_BITS{1'b0}}}) : '0;
    assign rad_z_next = (!sz[SUM_W-1] && (sz != '0))
                      ? RAD_W'({sz[SUM_W-2:0], {FRAC_BITS{1'b0}}}) : '0;

    assign dx = DIFF_W'(mat.m12) - DIFF_W'(mat.m21);
    assign dy = DIFF_W'(mat.m20) - DIFF_W'(mat.m02);
    assign dz = DIFF_W'(mat.m01) - DIFF_W'(mat.m10);

    assign sgn_next.x = dx[DIFF_W-1];
    assign sgn_next.y = dy[DIFF_W-1];
    assign sgn_next.z = dz[DIFF_W-1];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            rad_w_reg  <= rad_w_next;
            rad_x_reg  <= rad_x_next;
            rad_y_reg  <= rad_y_next;
            rad_z_reg  <= rad_z_next;
            sgn_reg[0] <= sgn_next;
        end
        // signs ride alongside the root stages
        for (int k = 1; k <= ROOT_W; k++)
        begin
            if (en[k])
            begin
                sgn_reg[k] <= sgn_reg[k-1];
            end
        end
    end

    // ---------------- square roots ----------------
    logic [ROOT_W-1:0] root_w, root_x, root_y, root_z;

    rmq_sqrt_pipe #(.ROOT_W(ROOT_W)) u_sqrt_w (
        .clk  (clk),
        .en   (en[ROOT_W:1]),
        .rad  (rad_w_reg),
        .root (root_w)
    );

    rmq_sqrt_pipe #(.ROOT_W(ROOT_W)) u_sqrt_x (
        .clk  (clk),
        .en   (en[ROOT_W:1]),
        .rad  (rad_x_reg),
        .root (root_x)
    );

    rmq_sqrt_pipe #(.ROOT_W(ROOT_W)) u_sqrt_y (
        .clk  (clk),
        .en   (en[ROOT_W:1]),
        .rad  (rad_y_reg),
        .root (root_y)
    );

    rmq_sqrt_pipe #(.ROOT_W(ROOT_W)) u_sqrt_z (
        .clk  (clk),
        .en   (en[ROOT_W:1]),
        .rad  (rad_z_reg),
        .root (root_z)
    );

    // ---------------- output stage: halve, saturate, apply sign ----------------
    function automatic logic [OUT_W-1:0] sat_mag(input logic [MAG_W-1:0] m);
        logic [EXT_W-1:0] e;
        e = EXT_W'(m);
        return (e > EXT_W'(MAG_MAX)) ? MAG_MAX : e[OUT_W-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] apply_sign(input logic [OUT_W-1:0] lim,
                                                     input logic neg);
        logic [DATA_W-1:0] p;
        p = {1'b0, lim};
        return neg ? (~p + DATA_W'(1)) : p;
    endfunction

    quat_t out_next;
    quat_t out_reg;
    sign_t sgn_last;

    assign sgn_last    = sgn_reg[ROOT_W];
    assign out_next.qw = sat_mag(root_w[ROOT_W-1:1]);
    assign out_next.qx = apply_sign(sat_mag(root_x[ROOT_W-1:1]), sgn_last.x);
    assign out_next.qy = apply_sign(sat_mag(root_y[ROOT_W-1:1]), sgn_last.y);
    assign out_next.qz = apply_sign(sat_mag(root_z[ROOT_W-1:1]), sgn_last.z);

    always_ff @(posedge clk)
    begin
        if (en[STAGES-1])
        begin
            out_reg <= out_next;
        end
    end

    assign quat = out_reg;

endmodule
